// ===== rtl/core/hkvs_pkg.sv =====
`default_nettype none
package hkvs_pkg;

    // table geometry
    localparam int NUM_BUCKETS = 1024;
    localparam int NODE_POOL   = 1024;
    localparam int BKT_W       = $clog2(NUM_BUCKETS);
    localparam int NODE_W      = $clog2(NODE_POOL);
    localparam int PTR_W       = NODE_W + 1;

    // murmur3 finalizer constants
    localparam logic [31:0] MIX_C1 = 32'h85eb_ca6b;
    localparam logic [31:0] MIX_C2 = 32'hc2b2_ae35;
    localparam logic [31:0] ABSENT = 32'hffff_ffff;

    // end of chain marker
    localparam logic [PTR_W-1:0] NO_NODE = PTR_W'(NODE_POOL);

    typedef enum logic [1:0] {
        CMD_PUT    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_GET    = 2'd2,
        CMD_NOP    = 2'd3
    } command_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_HEAD,
        S_HEADW,
        S_WALK,
        S_NODEW,
        S_EXEC,
        S_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic hash2;
        logic clr_step;
        logic head_load;
        logic advance;
        logic mark_found;
        logic execute;
        logic out_load;
    } dp_ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic clr_done;
        logic walk_end;
        logic key_hit;
        logic out_free;
    } dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/hkvs_ctrl.sv =====
`default_nettype none
module hkvs_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire hkvs_pkg::dp_stat_t stat,
    output hkvs_pkg::dp_ctrl_t      ctrl
);

    hkvs_pkg::state_t state_reg;
    hkvs_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hkvs_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hkvs_pkg::S_CLEAR:
            begin
                if (stat.clr_done)
                begin
                    state_next = hkvs_pkg::S_IDLE;
                end
            end
            hkvs_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = hkvs_pkg::S_HASH;
                end
            end
            hkvs_pkg::S_HASH:  state_next = hkvs_pkg::S_HEAD;
            hkvs_pkg::S_HEAD:  state_next = hkvs_pkg::S_HEADW;
            hkvs_pkg::S_HEADW: state_next = hkvs_pkg::S_WALK;
            hkvs_pkg::S_WALK:
            begin
                state_next = stat.walk_end ? hkvs_pkg::S_EXEC : hkvs_pkg::S_NODEW;
            end
            hkvs_pkg::S_NODEW:
            begin
                state_next = stat.key_hit ? hkvs_pkg::S_EXEC : hkvs_pkg::S_WALK;
            end
            hkvs_pkg::S_EXEC:  state_next = hkvs_pkg::S_OUT;
            hkvs_pkg::S_OUT:
            begin
                if (stat.out_free)
                begin
                    state_next = hkvs_pkg::S_IDLE;
                end
            end
            default:           state_next = hkvs_pkg::S_CLEAR;
        endcase
    end

    // datapath commands
    always_comb
    begin
        ctrl     = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            hkvs_pkg::S_CLEAR: ctrl.clr_step = !stat.clr_done;
            hkvs_pkg::S_IDLE:
            begin
                in_ready     = 1'b1;
                ctrl.capture = in_valid;
            end
            hkvs_pkg::S_HASH:  ctrl.hash2 = 1'b1;
            hkvs_pkg::S_HEAD:  ctrl = '0;
            hkvs_pkg::S_HEADW: ctrl.head_load = 1'b1;
            hkvs_pkg::S_WALK:  ctrl = '0;
            hkvs_pkg::S_NODEW:
            begin
                ctrl.mark_found = stat.key_hit;
                ctrl.advance    = !stat.key_hit;
            end
            hkvs_pkg::S_EXEC:  ctrl.execute = 1'b1;
            hkvs_pkg::S_OUT:   ctrl.out_load = stat.out_free;
            default:           ctrl = '0;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/core/hkvs_datapath.sv =====
`default_nettype none
module hkvs_datapath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire hkvs_pkg::dp_ctrl_t ctrl,
    output hkvs_pkg::dp_stat_t      stat,
    input  wire logic [1:0]         command,
    input  wire logic signed [31:0] key,
    input  wire logic signed [31:0] value,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      answer,
    output logic                    status
);

    localparam int NW = hkvs_pkg::NODE_W;
    localparam int PW = hkvs_pkg::PTR_W;
    localparam int BW = hkvs_pkg::BKT_W;

    // memories
    logic [PW-1:0] head_mem [hkvs_pkg::NUM_BUCKETS];
    logic [31:0]   key_mem  [hkvs_pkg::NODE_POOL];
    logic [31:0]   val_mem  [hkvs_pkg::NODE_POOL];
    logic [PW-1:0] link_mem [hkvs_pkg::NODE_POOL];
    logic [NW-1:0] free_mem [hkvs_pkg::NODE_POOL];

    // control registers
    logic [BW:0]   clr_cnt_reg;
    logic [PW-1:0] fresh_cnt_reg;
    logic [PW-1:0] freed_cnt_reg;
    logic          out_valid_reg;

    // payload registers
    logic [1:0]    cmd_reg;
    logic [31:0]   key_reg;
    logic [31:0]   val_reg;
    logic [31:0]   h_reg;
    logic [PW-1:0] head_reg;
    logic [PW-1:0] cur_reg;
    logic [PW-1:0] prev_reg;
    logic [PW-1:0] steps_reg;
    logic          found_reg;
    logic [31:0]   old_val_reg;
    logic [PW-1:0] old_link_reg;
    logic [31:0]   res_answer_reg;
    logic          res_status_reg;
    logic [31:0]   answer_reg;
    logic          status_reg;

    // memory read data
    logic [PW-1:0] head_q;
    logic [31:0]   key_q;
    logic [31:0]   val_q;
    logic [PW-1:0] link_q;
    logic [NW-1:0] free_q;

    // hash stages
    logic [31:0] in_key_u;
    logic [31:0] mix1;
    logic [31:0] mix2;
    logic [31:0] mix3;
    logic [BW-1:0] bucket;

    assign in_key_u = key;
    assign mix1     = (in_key_u ^ (in_key_u >> 16)) * hkvs_pkg::MIX_C1;
    assign mix2     = (h_reg ^ (h_reg >> 13)) * hkvs_pkg::MIX_C2;
    assign mix3     = h_reg ^ (h_reg >> 16);
    assign bucket   = mix3[BW-1:0];

    // node allocation
    logic          pool_full;
    logic [NW-1:0] alloc_idx;
    logic [NW-1:0] free_rd_addr;
    logic [NW-1:0] cur_idx;

    assign pool_full    = (freed_cnt_reg == '0) && (fresh_cnt_reg == PW'(hkvs_pkg::NODE_POOL));
    assign alloc_idx    = (freed_cnt_reg != '0) ? free_q : fresh_cnt_reg[NW-1:0];
    assign free_rd_addr = NW'(freed_cnt_reg - PW'(1));
    assign cur_idx      = cur_reg[NW-1:0];

    // command execution
    logic          head_we;
    logic [BW-1:0] head_wa;
    logic [PW-1:0] head_wd;
    logic          node_new;
    logic          val_we;
    logic [NW-1:0] val_wa;
    logic          link_we;
    logic [NW-1:0] link_wa;
    logic [PW-1:0] link_wd;
    logic          free_we;
    logic          take_fresh;
    logic          take_freed;
    logic [31:0]   exec_answer;
    logic          exec_status;

    always_comb
    begin
        head_we     = 1'b0;
        head_wa     = bucket;
        head_wd     = head_reg;
        node_new    = 1'b0;
        val_we      = 1'b0;
        val_wa      = cur_idx;
        link_we     = 1'b0;
        link_wa     = alloc_idx;
        link_wd     = head_reg;
        free_we     = 1'b0;
        take_fresh  = 1'b0;
        take_freed  = 1'b0;
        exec_answer = found_reg ? old_val_reg : hkvs_pkg::ABSENT;
        exec_status = 1'b0;
        if (ctrl.clr_step)
        begin
            head_we = 1'b1;
            head_wa = clr_cnt_reg[BW-1:0];
            head_wd = hkvs_pkg::NO_NODE;
        end
        else if (ctrl.execute)
        begin
            unique case (hkvs_pkg::command_t'(cmd_reg))
                hkvs_pkg::CMD_PUT:
                begin
                    if (found_reg)
                    begin
                        val_we = 1'b1;
                    end
                    else if (pool_full)
                    begin
                        exec_status = 1'b1;
                    end
                    else
                    begin
                        // new node at the chain head
                        node_new   = 1'b1;
                        val_we     = 1'b1;
                        val_wa     = alloc_idx;
                        link_we    = 1'b1;
                        head_we    = 1'b1;
                        head_wd    = PW'(alloc_idx);
                        take_freed = (freed_cnt_reg != '0);
                        take_fresh = (freed_cnt_reg == '0);
                    end
                end
                hkvs_pkg::CMD_REMOVE:
                begin
                    if (found_reg)
                    begin
                        // unlink from head or predecessor
                        if (prev_reg == hkvs_pkg::NO_NODE)
                        begin
                            head_we = 1'b1;
                            head_wd = old_link_reg;
                        end
                        else
                        begin
                            link_we = 1'b1;
                            link_wa = prev_reg[NW-1:0];
                            link_wd = old_link_reg;
                        end
                        free_we = 1'b1;
                    end
                end
                hkvs_pkg::CMD_GET: exec_answer = found_reg ? old_val_reg : hkvs_pkg::ABSENT;
                hkvs_pkg::CMD_NOP: exec_answer = hkvs_pkg::ABSENT;
                default:           exec_answer = hkvs_pkg::ABSENT;
            endcase
        end
    end

    // head memory
    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_mem[head_wa] <= head_wd;
        end
        head_q <= head_mem[bucket];
    end

    // node memories
    always_ff @(posedge clk)
    begin
        if (node_new)
        begin
            key_mem[alloc_idx] <= key_reg;
        end
        if (val_we)
        begin
            val_mem[val_wa] <= val_reg;
        end
        if (link_we)
        begin
            link_mem[link_wa] <= link_wd;
        end
        key_q  <= key_mem[cur_idx];
        val_q  <= val_mem[cur_idx];
        link_q <= link_mem[cur_idx];
    end

    // free stack memory
    always_ff @(posedge clk)
    begin
        if (free_we)
        begin
            free_mem[freed_cnt_reg[NW-1:0]] <= cur_idx;
        end
        free_q <= free_mem[free_rd_addr];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            fresh_cnt_reg <= '0;
            freed_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + (BW+1)'(1);
            end
            if (take_fresh)
            begin
                fresh_cnt_reg <= fresh_cnt_reg + PW'(1);
            end
            if (take_freed)
            begin
                freed_cnt_reg <= freed_cnt_reg - PW'(1);
            end
            else if (free_we)
            begin
                freed_cnt_reg <= freed_cnt_reg + PW'(1);
            end
            if (ctrl.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // request capture, hash, chain walk and result registers
    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            cmd_reg <= command;
            key_reg <= key;
            val_reg <= value;
            h_reg   <= mix1;
        end
        if (ctrl.hash2)
        begin
            h_reg <= mix2;
        end
        if (ctrl.head_load)
        begin
            head_reg  <= head_q;
            cur_reg   <= head_q;
            prev_reg  <= hkvs_pkg::NO_NODE;
            steps_reg <= '0;
            found_reg <= 1'b0;
        end
        if (ctrl.advance)
        begin
            prev_reg  <= cur_reg;
            cur_reg   <= link_q;
            steps_reg <= steps_reg + PW'(1);
        end
        if (ctrl.mark_found)
        begin
            found_reg    <= 1'b1;
            old_val_reg  <= val_q;
            old_link_reg <= link_q;
        end
        if (ctrl.execute)
        begin
            res_answer_reg <= exec_answer;
            res_status_reg <= exec_status;
        end
        if (ctrl.out_load)
        begin
            answer_reg <= res_answer_reg;
            status_reg <= res_status_reg;
        end
    end

    // status to controller
    assign stat.clr_done = (clr_cnt_reg == (BW+1)'(hkvs_pkg::NUM_BUCKETS));
    assign stat.walk_end = (cur_reg >= PW'(hkvs_pkg::NODE_POOL))
                        || (steps_reg == PW'(hkvs_pkg::NODE_POOL));
    assign stat.key_hit  = (key_q == key_reg);
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign answer    = answer_reg;
    assign status    = status_reg;

endmodule
`default_nettype wire

// ===== rtl/core/hashed_key_value_store.sv =====
// Chained hash table of 32-bit keys and values with a fixed node pool.
// Input channel (in_valid/in_ready): one request of command, key and value;
// command 0 put, 1 remove, 2 get, 3 does nothing and answers -1.
// Output channel (out_valid/out_ready): one result per request, answer is
// the previous, removed or found value or -1, status 1 when a put of a new
// key finds the node pool full.
// A request runs through the states hash, head read, head wait, chain walk
// with a node wait per node, execute and output, set by the two-stage hash
// and the single read port of the node memories; a found key goes from its
// node wait straight to execute. One request is worked on at a time and the
// next is taken in the cycle after the result is loaded.
// Reset clears the controller and then runs a clearing pass over the
// 1024 bucket heads, one per cycle; in_ready stays low for those cycles.
// The result sits in an output register: the next request is accepted while
// it waits, and when the receiver stalls the following result holds in the
// datapath until the output register frees, with in_ready low meanwhile.
`default_nettype none
module hashed_key_value_store (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         command,
    input  wire logic signed [31:0] key,
    input  wire logic signed [31:0] value,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      answer,
    output logic                    status
);

    hkvs_pkg::dp_ctrl_t ctrl;
    hkvs_pkg::dp_stat_t stat;

    // sequencer
    hkvs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    // hash, memories and result register
    hkvs_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .stat      (stat),
        .command   (command),
        .key       (key),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .answer    (answer),
        .status    (status)
    );

endmodule
`default_nettype wire
